// ===== src/amx_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// amx_pkg
// Shared types, codes and sizes of the accumulator machine execute core.
// ----------------------------------------------------------------------------
package amx_pkg;

  localparam int ADDR_W  = 16;
  localparam int TOTAL_W = 16;
  localparam int E_W     = 8;
  localparam int WORD_W  = TOTAL_W + E_W;
  localparam int PC_W    = 16;
  localparam int COUNT_W = 16;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic [E_W-1:0]     e;
    logic [TOTAL_W-1:0] total;
  } word_t;

  typedef enum logic [1:0] {
    MODE_EXEC = 2'd0,
    MODE_LOAD = 2'd1,
    MODE_READ = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef enum logic [7:0] {
    OP_HALT  = 8'h00,
    OP_LOAD  = 8'h01,
    OP_STORE = 8'h02,
    OP_ADD   = 8'h03,
    OP_SUB   = 8'h04,
    OP_SKIP  = 8'h05,
    OP_JZ    = 8'h06,
    OP_JNZ   = 8'h07,
    OP_JMP   = 8'h08,
    OP_SWAP  = 8'h09,
    OP_INC   = 8'h0A
  } opcode_t;

  typedef struct packed {
    logic [PC_W-1:0]    pc;
    logic               run;
    word_t              a;
    word_t              b;
    word_t              r;
    logic [COUNT_W-1:0] count;
  } arch_state_t;

  typedef struct packed {
    logic  en;
    addr_t addr;
    word_t data;
  } mem_wr_t;

endpackage
`default_nettype wire

// ===== src/amx_data_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// amx_data_ram
// Single-port-write, single-port-read synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module amx_data_ram #(
  parameter int ADDR_WIDTH = 16,
  parameter int DATA_WIDTH = 24
) (
  input  wire logic                  clk,
  input  wire logic                  wr_en,
  input  wire logic [ADDR_WIDTH-1:0] wr_addr,
  input  wire logic [DATA_WIDTH-1:0] wr_data,
  input  wire logic                  rd_en,
  input  wire logic [ADDR_WIDTH-1:0] rd_addr,
  output logic      [DATA_WIDTH-1:0] rd_data
);

  logic [DATA_WIDTH-1:0] mem [2**ADDR_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read-first: a same-cycle write is not seen here.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== src/amx_exec_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// amx_exec_unit
// Next-state logic: decodes one item against the current machine state.
// ----------------------------------------------------------------------------
module amx_exec_unit
  import amx_pkg::*;
(
  input  wire arch_state_t        cur,
  input  wire logic [1:0]         mode,
  input  wire logic [7:0]         opcode,
  input  wire logic [PC_W-1:0]    operand,
  input  wire word_t              load_word,
  input  wire word_t              mem_word,
  output arch_state_t             nxt,
  output logic                    bad,
  output word_t                   rd_word,
  output mem_wr_t                 wr
);

  logic [PC_W-1:0] pc_plus1;
  logic [PC_W-1:0] pc_plus3;
  logic            a_zero;
  addr_t           addr;

  assign pc_plus1 = cur.pc + PC_W'(1);
  assign pc_plus3 = cur.pc + PC_W'(3);
  assign a_zero   = (cur.a.total == '0);
  assign addr     = operand[ADDR_W-1:0];

  always_comb begin
    nxt     = cur;
    bad     = 1'b0;
    rd_word = '0;
    wr.en   = 1'b0;
    wr.addr = addr;
    wr.data = load_word;
    unique case (mode_t'(mode))
      MODE_EXEC: begin
        if (cur.run) begin
          unique case (opcode_t'(opcode))
            OP_HALT: begin
              nxt.run = 1'b0;
              nxt.pc  = pc_plus1;
            end
            OP_LOAD: begin
              nxt.b     = cur.a;
              nxt.a     = mem_word;
              nxt.pc    = pc_plus3;
              nxt.count = cur.count + COUNT_W'(1);
            end
            OP_STORE: begin
              nxt.r     = cur.a;
              wr.en     = 1'b1;
              wr.data   = cur.a;
              nxt.pc    = pc_plus3;
              nxt.count = cur.count + COUNT_W'(1);
            end
            OP_ADD: begin
              nxt.r.total = cur.a.total + cur.b.total;
              nxt.r.e     = cur.a.e + cur.b.e;
              nxt.pc      = pc_plus1;
              nxt.count   = cur.count + COUNT_W'(1);
            end
            OP_SUB: begin
              nxt.r.total = cur.a.total - cur.b.total;
              nxt.r.e     = cur.a.e - cur.b.e;
              nxt.pc      = pc_plus1;
              nxt.count   = cur.count + COUNT_W'(1);
            end
            OP_SKIP: nxt.pc = pc_plus3;
            OP_JZ:   nxt.pc = a_zero ? operand : pc_plus3;
            OP_JNZ:  nxt.pc = a_zero ? pc_plus3 : operand;
            OP_JMP:  nxt.pc = operand;
            OP_SWAP: begin
              nxt.a  = cur.b;
              nxt.b  = cur.a;
              nxt.pc = pc_plus1;
            end
            OP_INC: begin
              nxt.a.total = cur.a.total + TOTAL_W'(1);
              nxt.pc      = pc_plus1;
            end
            default: begin
              nxt.run = 1'b0;
              bad     = 1'b1;
            end
          endcase
        end
      end
      MODE_LOAD: wr.en   = 1'b1;
      MODE_READ: rd_word = mem_word;
      MODE_NONE: ;
      default:   ;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/accumulator_machine_execute_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// accumulator_machine_execute_top
// Execute core of a small accumulator machine with a 24-bit data store.
// ----------------------------------------------------------------------------
// Takes one item per cycle (execute, load data word, read data word) while
// the output is not stalled, and returns one result per item carrying the
// machine state after it. An item is transferred in and its data-store read
// is issued at that same edge; the item then waits in the execute stage
// register until the output register is free or being drained, executes,
// and its result lands in the output register. Results sustain one per
// cycle while the output is not stalled. The data-store read is registered.
// A store or load-mode write that lands on the same address the following
// item reads is forwarded around the memory. The data store is 2^ADDR_W
// words and holds no reset value: read only words written before.
// ----------------------------------------------------------------------------
module accumulator_machine_execute_top
  import amx_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [1:0]   mode,
  input  wire logic [7:0]   opcode,
  input  wire logic [15:0]  operand,
  input  wire logic [15:0]  load_total,
  input  wire logic [7:0]   load_e,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [15:0]       next_pc,
  output logic              halted,
  output logic              bad_opcode,
  output logic [15:0]       a_total,
  output logic [7:0]        a_e,
  output logic [15:0]       b_total,
  output logic [7:0]        b_e,
  output logic [15:0]       r_total,
  output logic [7:0]        r_e,
  output logic [15:0]       read_total,
  output logic [7:0]        read_e,
  output logic [15:0]       op_count
);

  // Architectural state
  arch_state_t state;
  arch_state_t state_next;

  // Execute stage: the item waiting for its memory word
  logic            ex_valid;
  logic [1:0]      ex_mode;
  logic [7:0]      ex_opcode;
  logic [PC_W-1:0] ex_operand;
  word_t           ex_load;
  logic            fwd_hit;
  word_t           fwd_word;

  logic    ex_fire;
  logic    in_fire;
  word_t   ram_q;
  word_t   mem_word;
  word_t   rd_word;
  logic    bad;
  mem_wr_t wr;
  logic    wr_en;
  addr_t   in_addr;

  // Execute when the output register is free or being drained.
  assign ex_fire  = ex_valid && (!out_valid || !out_stall);
  assign in_stall = ex_valid && !ex_fire;
  assign in_fire  = in_valid && !in_stall;
  assign in_addr  = operand[ADDR_W-1:0];
  assign wr_en    = ex_fire && wr.en;
  assign mem_word = fwd_hit ? fwd_word : ram_q;

  amx_data_ram #(
    .ADDR_WIDTH (ADDR_W),
    .DATA_WIDTH (WORD_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr.addr),
    .wr_data (wr.data),
    .rd_en   (in_fire),
    .rd_addr (in_addr),
    .rd_data (ram_q)
  );

  amx_exec_unit u_exec (
    .cur       (state),
    .mode      (ex_mode),
    .opcode    (ex_opcode),
    .operand   (ex_operand),
    .load_word (ex_load),
    .mem_word  (mem_word),
    .nxt       (state_next),
    .bad       (bad),
    .rd_word   (rd_word),
    .wr        (wr)
  );

  // Advance the execute stage; capture a bypass when the retiring item
  // writes the word the incoming item reads.
  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid <= 1'b0;
    end else if (in_fire) begin
      ex_valid <= 1'b1;
    end else if (ex_fire) begin
      ex_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      ex_mode       <= mode;
      ex_opcode     <= opcode;
      ex_operand    <= operand;
      ex_load.total <= load_total;
      ex_load.e     <= load_e;
      fwd_hit       <= wr_en && (wr.addr == in_addr);
      fwd_word      <= wr.data;
    end
  end

  // Commit the machine state as each item retires.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.pc    <= '0;
      state.run   <= 1'b1;
      state.a     <= '0;
      state.b     <= '0;
      state.r     <= '0;
      state.count <= '0;
    end else if (ex_fire) begin
      state <= state_next;
    end
  end

  // Output register: hold while stalled, drop valid once transferred.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ex_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_fire) begin
      next_pc    <= state_next.pc;
      halted     <= !state_next.run;
      bad_opcode <= bad;
      a_total    <= state_next.a.total;
      a_e        <= state_next.a.e;
      b_total    <= state_next.b.total;
      b_e        <= state_next.b.e;
      r_total    <= state_next.r.total;
      r_e        <= state_next.r.e;
      read_total <= rd_word.total;
      read_e     <= rd_word.e;
      op_count   <= state_next.count;
    end
  end

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the accumulator machine execute core.
// ----------------------------------------------------------------------------
// Drives a short table of hand-picked items and then constrained-random
// programs through the valid/stall input channel. Each transfer is run
// through a bench-side model of the machine, and the machine state it
// predicts is queued. Every result transfer is checked field by field
// against the oldest queued state. Both channels idle at random in the first
// two of three phases. A long output hold-off fills the pipe, and a mid-run
// pause drains it. The machine is halted only in the closing stretch, because
// nothing but a reset restarts it.
// ----------------------------------------------------------------------------
module tb
  import amx_pkg::*;
();

  localparam int HOLD_CYCLES  = 300;   // length of the long output hold-off
  localparam int QUIET_LIMIT  = 3000;  // cycles with no transfer before giving up
  localparam int DRAIN_CYCLES = 8;     // idle cycles after the last result; leave slack
  localparam int PHASE_ITEMS  = 290;
  localparam int TAIL_ITEMS   = 20;
  localparam int MAX_REPORTS  = 10;
  localparam int STORE_WORDS  = 1 << ADDR_W;

  // One input item, as the bench sees it.
  typedef struct packed {
    mode_t       mode;
    logic [7:0]  opcode;
    logic [15:0] operand;
    logic [15:0] ld_total;
    logic [7:0]  ld_e;
  } item_t;

  // Machine state reported by one result, in port order.
  typedef struct packed {
    logic [15:0] pc;
    logic        halted;
    logic        bad;
    word_t       a;
    word_t       b;
    word_t       r;
    word_t       rd;
    logic [15:0] count;
  } state_view_t;

  // A row of the directed table: the item, and optionally a hand-typed result.
  typedef struct packed {
    item_t       it;
    bit          typed;
    state_view_t want;
  } dir_row_t;

  localparam state_view_t RESET_VIEW = '0;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  mode = MODE_NONE;
  logic [7:0]  opcode = '0;
  logic [15:0] operand = '0;
  logic [15:0] load_total = '0;
  logic [7:0]  load_e = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] next_pc;
  logic        halted;
  logic        bad_opcode;
  logic [15:0] a_total;
  logic [7:0]  a_e;
  logic [15:0] b_total;
  logic [7:0]  b_e;
  logic [15:0] r_total;
  logic [7:0]  r_e;
  logic [15:0] read_total;
  logic [7:0]  read_e;
  logic [15:0] op_count;

  accumulator_machine_execute_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .opcode     (opcode),
    .operand    (operand),
    .load_total (load_total),
    .load_e     (load_e),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .next_pc    (next_pc),
    .halted     (halted),
    .bad_opcode (bad_opcode),
    .a_total    (a_total),
    .a_e        (a_e),
    .b_total    (b_total),
    .b_e        (b_e),
    .r_total    (r_total),
    .r_e        (r_e),
    .read_total (read_total),
    .read_e     (read_e),
    .op_count   (op_count)
  );

  always #5 clk = ~clk;

  // Bench copy of the architectural state.
  logic [15:0] cur_pc;
  logic        running;
  word_t       cur_a;
  word_t       cur_b;
  word_t       cur_r;
  logic [15:0] mem_ops;
  word_t       data_mem [0:STORE_WORDS-1];
  bit          data_known [0:STORE_WORDS-1];
  addr_t       known_addrs[$];
  addr_t       newest_addr;

  state_view_t pending_states[$];
  dir_row_t    dir_table[$];
  int          fail_count = 0;
  int          quiet_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_requests = 0;
  state_view_t seen_state;
  state_view_t due_state;

  // Record a data word write; remember the address as safe to read back.
  function automatic void note_write(addr_t addr, word_t w);
    data_mem[addr] = w;
    newest_addr = addr;
    if (!data_known[addr]) begin
      data_known[addr] = 1'b1;
      known_addrs.push_back(addr);
    end
  endfunction

  // Advance the bench machine by one item and return the state it reports.
  function automatic state_view_t machine_step(item_t it);
    addr_t addr;
    word_t rd;
    logic  bad;
    word_t swap_tmp;
    addr = it.operand[ADDR_W-1:0];
    rd   = '0;
    bad  = 1'b0;
    case (it.mode)
      MODE_EXEC: begin
        if (running) begin
          case (it.opcode)
            OP_HALT: begin
              running = 1'b0;
              cur_pc  = cur_pc + 16'd1;
            end
            OP_LOAD: begin
              cur_b   = cur_a;
              cur_a   = data_mem[addr];
              cur_pc  = cur_pc + 16'd3;
              mem_ops = mem_ops + 16'd1;
            end
            OP_STORE: begin
              cur_r = cur_a;
              note_write(addr, cur_a);
              cur_pc  = cur_pc + 16'd3;
              mem_ops = mem_ops + 16'd1;
            end
            OP_ADD: begin
              cur_r.total = cur_a.total + cur_b.total;
              cur_r.e     = cur_a.e + cur_b.e;
              cur_pc  = cur_pc + 16'd1;
              mem_ops = mem_ops + 16'd1;
            end
            OP_SUB: begin
              cur_r.total = cur_a.total - cur_b.total;
              cur_r.e     = cur_a.e - cur_b.e;
              cur_pc  = cur_pc + 16'd1;
              mem_ops = mem_ops + 16'd1;
            end
            OP_SKIP: cur_pc = cur_pc + 16'd3;
            OP_JZ:   cur_pc = (cur_a.total == '0) ? it.operand : cur_pc + 16'd3;
            OP_JNZ:  cur_pc = (cur_a.total != '0) ? it.operand : cur_pc + 16'd3;
            OP_JMP:  cur_pc = it.operand;
            OP_SWAP: begin
              swap_tmp = cur_a;
              cur_a    = cur_b;
              cur_b    = swap_tmp;
              cur_pc   = cur_pc + 16'd1;
            end
            OP_INC: begin
              cur_a.total = cur_a.total + 16'd1;
              cur_pc      = cur_pc + 16'd1;
            end
            default: begin
              // unknown opcode: stop in place and flag it
              running = 1'b0;
              bad     = 1'b1;
            end
          endcase
        end
      end
      MODE_LOAD: note_write(addr, {it.ld_e, it.ld_total});
      MODE_READ: rd = data_mem[addr];
      default: ;
    endcase
    return {cur_pc, ~running, bad, cur_a, cur_b, cur_r, rd, mem_ops};
  endfunction

  // Read addresses come only from words already written; favor the newest
  // one so that a write followed directly by its read-back shows up often.
  function automatic addr_t written_addr();
    if ($urandom_range(3) == 0) return newest_addr;
    return known_addrs[$urandom_range(known_addrs.size() - 1)];
  endfunction

  // Write addresses: half from a small pool so that words get overwritten.
  function automatic addr_t fresh_addr();
    int roll;
    roll = $urandom_range(3);
    if (roll < 2) return addr_t'($urandom_range(31));
    if (roll == 2) return addr_t'($urandom_range(STORE_WORDS - 1));
    return written_addr();
  endfunction

  // Draw one random item. Before the halt, execute items carry only defined
  // opcodes but halt, so the machine keeps running; after it, any opcode goes.
  function automatic item_t pick_item(bit after_halt);
    item_t it;
    int    roll;
    it.mode     = MODE_EXEC;
    it.opcode   = 8'($urandom_range(255));
    it.operand  = 16'($urandom_range(16'hFFFF));
    it.ld_total = 16'($urandom_range(16'hFFFF));
    it.ld_e     = 8'($urandom_range(255));
    roll = $urandom_range(99);
    if (roll < 25) begin
      it.mode    = MODE_LOAD;
      it.operand = fresh_addr();
      // zero totals keep both branches of the conditional jumps busy
      if ($urandom_range(4) == 0) it.ld_total = '0;
    end else if (roll < 40) begin
      it.mode    = MODE_READ;
      it.operand = written_addr();
    end else if (roll < 45) begin
      it.mode = MODE_NONE;
    end else begin
      if (!after_halt) it.opcode = 8'($urandom_range(OP_LOAD, OP_INC));
      case (it.opcode)
        OP_LOAD:  it.operand = written_addr();
        OP_STORE: it.operand = fresh_addr();
        default: ;
      endcase
    end
    return it;
  endfunction

  function automatic dir_row_t row(mode_t m, logic [7:0] op, logic [15:0] opnd,
                                   logic [15:0] lt, logic [7:0] le);
    return {m, op, opnd, lt, le, 1'b0, RESET_VIEW};
  endfunction

  function automatic dir_row_t row_known(mode_t m, logic [7:0] op, logic [15:0] opnd,
                                         logic [15:0] lt, logic [7:0] le,
                                         state_view_t want);
    return {m, op, opnd, lt, le, 1'b1, want};
  endfunction

  // Offer one item, hold it until the transfer, then queue its expected state.
  // A hand-typed result, where given, takes the place of the predicted one.
  task automatic transfer_item(item_t it, bit typed, state_view_t want);
    state_view_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= it.mode;
    opcode     <= it.opcode;
    operand    <= it.operand;
    load_total <= it.ld_total;
    load_e     <= it.ld_e;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = machine_step(it);
    pending_states.push_back(typed ? want : predicted);
  endtask

  // Stimulus: directed table, three random phases, then the halt and what
  // follows it.
  initial begin : stimulus
    item_t it;
    cur_pc  = '0;
    running = 1'b1;
    cur_a   = '0;
    cur_b   = '0;
    cur_r   = '0;
    mem_ops = '0;

    // extremes from reset; the machine registers here stay at their reset state
    dir_table.push_back(row_known(MODE_NONE, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, RESET_VIEW));
    dir_table.push_back(row_known(MODE_LOAD, 8'h00, 16'h0000, 16'hFFFF, 8'hFF, RESET_VIEW));
    dir_table.push_back(row_known(MODE_LOAD, 8'h00, 16'hFFFF, 16'h0001, 8'h01, RESET_VIEW));
    dir_table.push_back(row_known(MODE_LOAD, 8'h00, 16'h1234, 16'h0000, 8'h00, RESET_VIEW));
    dir_table.push_back(row_known(MODE_READ, 8'h00, 16'h0000, 16'h0000, 8'h00,
                                  {RESET_VIEW[129:40], 8'hFF, 16'hFFFF, 16'h0000}));
    dir_table.push_back(row_known(MODE_READ, 8'h00, 16'hFFFF, 16'h0000, 8'h00,
                                  {RESET_VIEW[129:40], 8'h01, 16'h0001, 16'h0000}));
    // every opcode but halt; total and pc wrap, both jump outcomes
    dir_table.push_back(row(MODE_EXEC, OP_INC,   16'h0000, 16'h0000, 8'h00));
    dir_table.push_back(row(MODE_EXEC, OP_LOAD,  16'h0000, 16'h0000, 8'h00));
    dir_table.push_back(row(MODE_EXEC, OP_INC,   16'h0000, 16'h0000, 8'h00));
    dir_table.push_back(row(MODE_EXEC, OP_ADD,   16'h0000, 16'h0000, 8'h00));
    dir_table.push_back(row(MODE_EXEC, OP_SUB,   16'h0000, 16'h0000, 8'h00));
    dir_table.push_back(row(MODE_EXEC, OP_STORE, 16'h8000, 16'h0000, 8'h00));
    dir_table.push_back(row(MODE_EXEC, OP_JZ,    16'hBEEF, 16'h0000, 8'h00));
    dir_table.push_back(row(MODE_EXEC, OP_JNZ,   16'h1111, 16'h0000, 8'h00));
    dir_table.push_back(row(MODE_EXEC, OP_SWAP,  16'h0000, 16'h0000, 8'h00));
    dir_table.push_back(row(MODE_EXEC, OP_JNZ,   16'hFFFF, 16'h0000, 8'h00));
    dir_table.push_back(row(MODE_EXEC, OP_SKIP,  16'h0000, 16'h0000, 8'h00));
    dir_table.push_back(row(MODE_EXEC, OP_JZ,    16'h0000, 16'h0000, 8'h00));
    dir_table.push_back(row(MODE_EXEC, OP_JMP,   16'hFFFE, 16'h0000, 8'h00));
    dir_table.push_back(row(MODE_EXEC, OP_INC,   16'h0000, 16'h0000, 8'h00));
    dir_table.push_back(row(MODE_EXEC, OP_SWAP,  16'h0000, 16'h0000, 8'h00));
    dir_table.push_back(row(MODE_READ, 8'h00,    16'h8000, 16'h0000, 8'h00));
    // halt code in the unused mode must not stop the machine
    dir_table.push_back(row(MODE_NONE, OP_HALT,  16'h0000, 16'h0000, 8'h00));
    dir_table.push_back(row(MODE_EXEC, OP_LOAD,  16'hFFFF, 16'h0000, 8'h00));
    dir_table.push_back(row(MODE_LOAD, 8'h00,    16'h5A5A, 16'hA5A5, 8'h5A));

    send_idle_pct = 24;
    recv_idle_pct = 59;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_table[i]) transfer_item(dir_table[i].it, dir_table[i].typed,
                                         dir_table[i].want);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 24;
          recv_idle_pct = 59;
        end
        1: begin
          send_idle_pct = 59;
          recv_idle_pct = 24;
        end
        default: begin
          // no idling; open with a long hold-off so the pipe backs up
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_requests = hold_requests + 1;
        end
      endcase
      repeat (PHASE_ITEMS) begin
        it = pick_item(1'b0);
        transfer_item(it, 1'b0, RESET_VIEW);
      end
      if (phase == 0) begin
        // drop valid and let every outstanding result drain
        in_valid <= 1'b0;
        while (pending_states.size() != 0) @(posedge clk);
      end
    end

    // Stop the machine by a halt or an unknown opcode, picked at random;
    // afterwards execute items are ignored while loads and reads go on.
    it = pick_item(1'b0);
    it.mode = MODE_EXEC;
    if ($urandom_range(1) == 0) it.opcode = OP_HALT;
    else it.opcode = 8'($urandom_range(int'(OP_INC) + 1, 255));
    transfer_item(it, 1'b0, RESET_VIEW);
    repeat (TAIL_ITEMS) begin
      it = pick_item(1'b1);
      transfer_item(it, 1'b0, RESET_VIEW);
    end

    in_valid <= 1'b0;
    while (pending_states.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_states.size() == 0) begin
      $display("accumulator_machine_execute_top verification clean");
    end else begin
      $display("accumulator_machine_execute_top verification failed");
    end
    $finish;
  end

  // Output side: random stall per phase; on request, hold stall high for a
  // long stretch counted here while the sender keeps offering items.
  initial begin : receiver
    int seen_holds;
    seen_holds = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != seen_holds) begin
        seen_holds = hold_requests;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Check each result transfer against the oldest queued state.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      seen_state = {next_pc, halted, bad_opcode, a_e, a_total, b_e, b_total,
                    r_e, r_total, read_e, read_total, op_count};
      if (pending_states.size() == 0) begin
        if (fail_count < MAX_REPORTS)
          $display("%0t: result with nothing pending: pc %h A %h B %h R %h",
                   $realtime, seen_state.pc, seen_state.a, seen_state.b, seen_state.r);
        fail_count = fail_count + 1;
      end else begin
        due_state = pending_states.pop_front();
        if (seen_state !== due_state) begin
          if (fail_count < MAX_REPORTS) begin
            $display("%0t: mismatch (expected/actual) pc %h/%h halted %b/%b bad %b/%b",
                     $realtime, due_state.pc, seen_state.pc, due_state.halted,
                     seen_state.halted, due_state.bad, seen_state.bad);
            $display("  A %h/%h B %h/%h R %h/%h read %h/%h count %h/%h",
                     due_state.a, seen_state.a, due_state.b, seen_state.b,
                     due_state.r, seen_state.r, due_state.rd, seen_state.rd,
                     due_state.count, seen_state.count);
          end
          fail_count = fail_count + 1;
        end
      end
    end
  end

  // Watchdog: give up after a long run of cycles with no transfer on either side.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("accumulator_machine_execute_top verification failed");
      $finish;
    end
  end

endmodule

// ===== files.f =====
src/amx_pkg.sv
src/amx_data_ram.sv
src/amx_exec_unit.sv
src/accumulator_machine_execute_top.sv
verif/tb.sv
